>>> hdl/s2uv_pkg.sv
package s2uv_pkg;

  // Internal CORDIC word: Q2.30 with headroom for the unfolded angle range.
  localparam int ANG_W = 34;
  localparam int ATAN_ENTRIES = 24;

  typedef logic signed [ANG_W-1:0] s2uv_word_t;

  typedef struct packed {
    s2uv_word_t x;
    s2uv_word_t y;
    s2uv_word_t z;
  } s2uv_rot_t;

  // Payload handed from cell to cell.
  typedef struct packed {
    s2uv_rot_t lon;
    s2uv_rot_t lat;
    logic      neg_lon;
    logic      neg_lat;
    logic      last;
  } s2uv_cell_t;

  typedef struct packed {
    s2uv_word_t z;
    logic       neg;
  } s2uv_fold_t;

  localparam logic signed [17:0] LON_BOUND = 18'sd102944;
  localparam logic signed [16:0] LAT_BOUND = 17'sd51472;
  localparam s2uv_word_t HALF_PI_Q30 = 34'sd1686629713;
  localparam s2uv_word_t PI_Q30      = 34'sd3373259426;
  localparam s2uv_word_t K_INF_Q30   = 34'sd652032874;
  // Two thirds of the gain constant, used for the finite-length correction.
  localparam s2uv_word_t K_TWO_THIRDS = 34'sd434688582;

  localparam logic signed [17:0] OUT_ONE = 18'sd65536;
  localparam logic signed [63:0] PROD_HALF = 64'sh0000_0800_0000_0000;
  localparam s2uv_word_t SIN_HALF = 34'sh0_0000_2000;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  // Folds an angle outside [-pi/2, pi/2] back by pi; results get negated later.
  function automatic s2uv_fold_t fold(input s2uv_word_t a);
    s2uv_fold_t f;
    f.z   = a;
    f.neg = 1'b0;
    if (a > HALF_PI_Q30) begin
      f.z   = a - PI_Q30;
      f.neg = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      f.z   = a + PI_Q30;
      f.neg = 1'b1;
    end
    return f;
  endfunction

  // Saturates a wide signed value to the unit range of the Q2.16 output.
  function automatic logic signed [17:0] sat_unit(input logic signed [63:0] v);
    logic signed [17:0] r;
    if (v > 64'(OUT_ONE)) begin
      r = OUT_ONE;
    end else if (v < -64'(OUT_ONE)) begin
      r = -OUT_ONE;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/spherical_to_unit_vector_top.sv
// Spherical to unit vector converter. Each transaction carries one point as
// longitude in signed Q3.15 and latitude in signed Q2.15 radians (saturated
// to [-pi, pi] and [-pi/2, pi/2]) and returns one transaction with
// x = cos(lat)cos(lon), y = cos(lat)sin(lon) and z = sin(lat) in signed
// Q2.16, plus the last-point flag copied through. The block accepts one
// point per clock cycle unless the input side is stalled. Its stages are one
// input stage that saturates and folds the angles, one CORDIC cell per
// iteration (each cell rotates both angles at once), one multiplier stage and
// one output register. Every stage holds its own valid bit and only waits when
// the stage after it is full, so stall on the result side backs up one stage
// at a time and points keep entering as long as any stage in the chain is empty.

module spherical_to_unit_vector_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [17:0]  in_longitude,
  input  logic signed [16:0]  in_latitude,
  input  logic                in_last_point,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [17:0]  out_x_component,
  output logic signed [17:0]  out_y_component,
  output logic signed [17:0]  out_z_component,
  output logic                out_last_out
);

  // Cells beyond the arctangent table are not built.
  localparam int NCELL = (CORDIC_STAGES < s2uv_pkg::ATAN_ENTRIES) ?
                         CORDIC_STAGES : s2uv_pkg::ATAN_ENTRIES;
  localparam int DEPTH = NCELL + 3;
  localparam int OCC_W = $clog2(DEPTH + 1);

  // Index 0 is the input stage; index k is cell k-1's output.
  logic                 vld   [NCELL+1];
  s2uv_pkg::s2uv_cell_t dat   [NCELL+1];
  logic                 ready [NCELL+1];
  logic                 in_ready;
  logic                 in_take;
  logic                 out_take;
  logic [OCC_W-1:0]     occ_r;
  logic [OCC_W-1:0]     occ_nxt;

  s2uv_front #(
    .CORDIC_STAGES (NCELL)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_longitude  (in_longitude),
    .in_latitude   (in_latitude),
    .in_last_point (in_last_point),
    .ready_i       (ready[0]),
    .ready_o       (in_ready),
    .vld_o         (vld[0]),
    .dat_o         (dat[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    s2uv_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_i   (vld[g]),
      .dat_i   (dat[g]),
      .ready_i (ready[g+1]),
      .ready_o (ready[g]),
      .vld_o   (vld[g+1]),
      .dat_o   (dat[g+1])
    );
  end

  s2uv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .vld_i           (vld[NCELL]),
    .dat_i           (dat[NCELL]),
    .ready_o         (ready[NCELL]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_component (out_x_component),
    .out_y_component (out_y_component),
    .out_z_component (out_z_component),
    .out_last_out    (out_last_out)
  );

  assign in_stall = !in_ready;
  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && !out_stall;

  // Number of points inside the chain; it bounds what the stages can hold.
  always_comb begin
    occ_nxt = occ_r;
    if (in_take && !out_take) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (!in_take && out_take) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // The input side only stalls when the result side holds a stalled result.
  a_stall_backs_up : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register is free");

  // The chain never holds more points than it has stages.
  a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("more points in flight than stages");

  // A result is never shown with no point inside the chain.
  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> !out_valid)
    else $error("result shown with the chain empty");

  // A full chain with a stalled result must stall the input side.
  a_full_stalls : assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_r == OCC_W'(DEPTH)) && out_stall) |-> in_stall)
    else $error("input accepted into a full chain");

  // Results stay within the unit range.
  a_unit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_x_component <= s2uv_pkg::OUT_ONE) &&
                   (out_x_component >= -s2uv_pkg::OUT_ONE) &&
                   (out_y_component <= s2uv_pkg::OUT_ONE) &&
                   (out_y_component >= -s2uv_pkg::OUT_ONE) &&
                   (out_z_component <= s2uv_pkg::OUT_ONE) &&
                   (out_z_component >= -s2uv_pkg::OUT_ONE)))
    else $error("result outside the unit range");

endmodule

>>> hdl/s2uv_front.sv
module s2uv_front #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic signed [17:0]       in_longitude,
  input  logic signed [16:0]       in_latitude,
  input  logic                     in_last_point,
  input  logic                     ready_i,
  output logic                     ready_o,
  output logic                     vld_o,
  output s2uv_pkg::s2uv_cell_t     dat_o
);

  localparam s2uv_pkg::s2uv_word_t GAIN =
    s2uv_pkg::K_INF_Q30 + (s2uv_pkg::K_TWO_THIRDS >>> (2 * CORDIC_STAGES));

  logic signed [17:0]         lon_sat;
  logic signed [16:0]         lat_sat;
  s2uv_pkg::s2uv_fold_t       lon_fold;
  s2uv_pkg::s2uv_fold_t       lat_fold;
  s2uv_pkg::s2uv_cell_t       dat_nxt;
  s2uv_pkg::s2uv_cell_t       dat_r;
  logic                       vld_r;

  always_comb begin
    if (in_longitude > s2uv_pkg::LON_BOUND) begin
      lon_sat = s2uv_pkg::LON_BOUND;
    end else if (in_longitude < -s2uv_pkg::LON_BOUND) begin
      lon_sat = -s2uv_pkg::LON_BOUND;
    end else begin
      lon_sat = in_longitude;
    end
    if (in_latitude > s2uv_pkg::LAT_BOUND) begin
      lat_sat = s2uv_pkg::LAT_BOUND;
    end else if (in_latitude < -s2uv_pkg::LAT_BOUND) begin
      lat_sat = -s2uv_pkg::LAT_BOUND;
    end else begin
      lat_sat = in_latitude;
    end
    // Q3.15 to Q2.30 is a left shift by 15.
    lon_fold = s2uv_pkg::fold({{(s2uv_pkg::ANG_W-33){lon_sat[17]}}, lon_sat, 15'b0});
    lat_fold = s2uv_pkg::fold({{(s2uv_pkg::ANG_W-32){lat_sat[16]}}, lat_sat, 15'b0});
    dat_nxt.lon.x   = GAIN;
    dat_nxt.lon.y   = '0;
    dat_nxt.lon.z   = lon_fold.z;
    dat_nxt.lat.x   = GAIN;
    dat_nxt.lat.y   = '0;
    dat_nxt.lat.z   = lat_fold.z;
    dat_nxt.neg_lon = lon_fold.neg;
    dat_nxt.neg_lat = lat_fold.neg;
    dat_nxt.last    = in_last_point;
  end

  assign ready_o = !vld_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && in_valid) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

>>> hdl/s2uv_cell.sv
module s2uv_cell #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  s2uv_pkg::s2uv_cell_t dat_i,
  input  logic                 ready_i,
  output logic                 ready_o,
  output logic                 vld_o,
  output s2uv_pkg::s2uv_cell_t dat_o
);

  localparam s2uv_pkg::s2uv_word_t ATAN =
    s2uv_pkg::s2uv_word_t'(s2uv_pkg::ATAN_Q30[IDX]);

  // One rotation-mode micro-rotation; both updates use the old x and y.
  function automatic s2uv_pkg::s2uv_rot_t rotate(input s2uv_pkg::s2uv_rot_t r);
    s2uv_pkg::s2uv_rot_t  o;
    s2uv_pkg::s2uv_word_t dx;
    s2uv_pkg::s2uv_word_t dy;
    dx = $signed(r.y) >>> IDX;
    dy = $signed(r.x) >>> IDX;
    if (!r.z[s2uv_pkg::ANG_W-1]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - ATAN;
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + ATAN;
    end
    return o;
  endfunction

  s2uv_pkg::s2uv_cell_t dat_nxt;
  s2uv_pkg::s2uv_cell_t dat_r;
  logic                 vld_r;

  always_comb begin
    dat_nxt     = dat_i;
    dat_nxt.lon = rotate(dat_i.lon);
    dat_nxt.lat = rotate(dat_i.lat);
  end

  assign ready_o = !vld_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

>>> hdl/s2uv_back.sv
module s2uv_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  s2uv_pkg::s2uv_cell_t dat_i,
  output logic                 ready_o,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [17:0]   out_x_component,
  output logic signed [17:0]   out_y_component,
  output logic signed [17:0]   out_z_component,
  output logic                 out_last_out
);

  s2uv_pkg::s2uv_word_t clon;
  s2uv_pkg::s2uv_word_t slon;
  s2uv_pkg::s2uv_word_t clat;
  s2uv_pkg::s2uv_word_t slat;
  logic signed [31:0]   clon_n;
  logic signed [31:0]   slon_n;
  logic signed [31:0]   clat_n;
  logic signed [63:0]   prod_x_nxt;
  logic signed [63:0]   prod_y_nxt;
  logic signed [63:0]   prod_x_r;
  logic signed [63:0]   prod_y_r;
  s2uv_pkg::s2uv_word_t slat_r;
  logic                 last_r;
  logic                 pv_r;
  logic                 out_ready;
  logic signed [63:0]   rnd_x;
  logic signed [63:0]   rnd_y;
  s2uv_pkg::s2uv_word_t rnd_z;
  logic signed [17:0]   x_nxt;
  logic signed [17:0]   y_nxt;
  logic signed [17:0]   z_nxt;
  logic                 ov_r;
  logic signed [17:0]   x_r;
  logic signed [17:0]   y_r;
  logic signed [17:0]   z_r;
  logic                 lo_r;

  // Undo the fold, then narrow: the unit-range values fit 32 signed bits.
  always_comb begin
    clon = dat_i.neg_lon ? -dat_i.lon.x : dat_i.lon.x;
    slon = dat_i.neg_lon ? -dat_i.lon.y : dat_i.lon.y;
    clat = dat_i.neg_lat ? -dat_i.lat.x : dat_i.lat.x;
    slat = dat_i.neg_lat ? -dat_i.lat.y : dat_i.lat.y;
    clon_n = clon[31:0];
    slon_n = slon[31:0];
    clat_n = clat[31:0];
    prod_x_nxt = clat_n * clon_n;
    prod_y_nxt = clat_n * slon_n;
  end

  assign out_ready = !ov_r || !out_stall;
  assign ready_o   = !pv_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (ready_o) begin
      pv_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && vld_i) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      slat_r   <= slat;
      last_r   <= dat_i.last;
    end
  end

  // Round to nearest Q2.16 and clip to the unit range.
  always_comb begin
    rnd_x = (prod_x_r + s2uv_pkg::PROD_HALF) >>> 44;
    rnd_y = (prod_y_r + s2uv_pkg::PROD_HALF) >>> 44;
    rnd_z = (slat_r + s2uv_pkg::SIN_HALF) >>> 14;
    x_nxt = s2uv_pkg::sat_unit(rnd_x);
    y_nxt = s2uv_pkg::sat_unit(rnd_y);
    z_nxt = s2uv_pkg::sat_unit(64'(rnd_z));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_ready) begin
      ov_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && pv_r) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      lo_r <= last_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_x_component = x_r;
  assign out_y_component = y_r;
  assign out_z_component = z_r;
  assign out_last_out    = lo_r;

endmodule
